// ===== src/thldb_pkg.sv =====
// Shared constants, codes and types for the thick line disk brush raster.
package thldb_pkg;

    localparam int DEF_MAX_CANVAS    = 4096;
    localparam int DEF_MAX_THICKNESS = 255;
    localparam int DEF_COORD_BITS    = 14;

    localparam int CANVAS_REG_BITS = 13;
    localparam int THICK_BITS      = 8;
    localparam int PIX_BITS        = 12;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 13;

    localparam logic [CANVAS_REG_BITS-1:0] RST_WIDTH  = 13'd1024;
    localparam logic [CANVAS_REG_BITS-1:0] RST_HEIGHT = 13'd768;
    localparam logic [THICK_BITS-1:0]      RST_THICK  = 8'd2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH     = 2'd0,
        CFG_HEIGHT    = 2'd1,
        CFG_THICKNESS = 2'd2
    } t_cfg_index;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    typedef struct packed {
        logic                erase;
        logic [PIX_BITS-1:0] px;
        logic [PIX_BITS-1:0] py;
        logic                done;
    } t_result;

endpackage

// ===== src/thldb_cfg.sv =====
// Configuration registers with clamped canvas size and brush radius.
module thldb_cfg
    import thldb_pkg::*;
#(
    parameter int MAX_CANVAS    = DEF_MAX_CANVAS,
    parameter int MAX_THICKNESS = DEF_MAX_THICKNESS,
    parameter int CANVW         = $clog2(MAX_CANVAS + 1),
    parameter int RW            = $clog2(MAX_THICKNESS / 2 + 2)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr,
    input  logic [CFG_IDX_BITS-1:0]  i_index,
    input  logic [CFG_DATA_BITS-1:0] i_data,
    output logic [CANVW-1:0]         o_width,
    output logic [CANVW-1:0]         o_height,
    output logic [RW-1:0]            o_radius
);

    logic [CANVAS_REG_BITS-1:0] r_width, r_height;
    logic [THICK_BITS-1:0]      r_thick;
    int unsigned                thick_c;
    int unsigned                half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_thick  <= RST_THICK;
        end else if (i_wr) begin
            case (t_cfg_index'(i_index))
                CFG_WIDTH:     r_width  <= i_data[CANVAS_REG_BITS-1:0];
                CFG_HEIGHT:    r_height <= i_data[CANVAS_REG_BITS-1:0];
                CFG_THICKNESS: r_thick  <= i_data[THICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_width  = (32'(r_width) > MAX_CANVAS)  ? CANVW'(MAX_CANVAS) : CANVW'(r_width);
        o_height = (32'(r_height) > MAX_CANVAS) ? CANVW'(MAX_CANVAS) : CANVW'(r_height);
        thick_c  = (32'(r_thick) > MAX_THICKNESS) ? 32'(MAX_THICKNESS) : 32'(r_thick);
        half     = thick_c >> 1;
        o_radius = (half == 0) ? RW'(1) : RW'(half);
    end

endmodule

// ===== src/thldb_walk.sv =====
// Line walk state, square scan offsets and per-candidate disk and canvas test.
module thldb_walk
    import thldb_pkg::*;
#(
    parameter int COORD_BITS    = DEF_COORD_BITS,
    parameter int MAX_CANVAS    = DEF_MAX_CANVAS,
    parameter int MAX_THICKNESS = DEF_MAX_THICKNESS,
    parameter int CANVW         = $clog2(MAX_CANVAS + 1),
    parameter int RW            = $clog2(MAX_THICKNESS / 2 + 2)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_op,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [CANVW-1:0]      i_width,
    input  logic [CANVW-1:0]      i_height,
    input  logic [RW-1:0]         i_radius,
    output t_result               o_result,
    output logic                  o_active
);

    localparam int OFFW = RW + 1;
    localparam int EW   = COORD_BITS + 2;
    localparam int CW0  = (COORD_BITS > OFFW) ? COORD_BITS : OFFW;
    localparam int CW   = ((CW0 > CANVW) ? CW0 : CANVW) + 2;
    localparam int SQW  = 2 * OFFW + 3;

    logic                         r_active;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_tx, r_ty;
    logic [COORD_BITS-1:0]        r_dx, r_dy;
    logic                         r_neg_x, r_neg_y;
    logic signed [EW-1:0]         r_err;
    logic [OFFW-1:0]              r_col, r_row;

    logic                         n_active;
    logic signed [COORD_BITS-1:0] n_px, n_py, n_tx, n_ty;
    logic [COORD_BITS-1:0]        n_dx, n_dy;
    logic                         n_neg_x, n_neg_y;
    logic signed [EW-1:0]         n_err;
    logic [OFFW-1:0]              n_col, n_row;

    logic signed [COORD_BITS:0]   diff_x, diff_y;
    logic signed [OFFW:0]         dc, dr;
    logic signed [SQW-1:0]        dcx, drx, rx, dist_sq, rad_sq;
    logic signed [CW-1:0]         ix, iy, wx, hx;
    logic [OFFW-1:0]              two_r;
    logic signed [EW:0]           e2;
    logic                         in_disk, on_canvas, step_x, step_y;

    always_comb begin
        n_active = r_active;
        n_px = r_px;   n_py = r_py;   n_tx = r_tx;   n_ty = r_ty;
        n_dx = r_dx;   n_dy = r_dy;
        n_neg_x = r_neg_x;  n_neg_y = r_neg_y;
        n_err = r_err;
        n_col = r_col;  n_row = r_row;
        o_result = '0;

        diff_x = (COORD_BITS + 1)'(signed'(i_end_x)) - (COORD_BITS + 1)'(signed'(i_start_x));
        diff_y = (COORD_BITS + 1)'(signed'(i_end_y)) - (COORD_BITS + 1)'(signed'(i_start_y));

        dc    = signed'({1'b0, r_col}) - signed'({2'b00, i_radius});
        dr    = signed'({1'b0, r_row}) - signed'({2'b00, i_radius});
        dcx   = SQW'(dc);
        drx   = SQW'(dr);
        rx    = SQW'(signed'({1'b0, i_radius}));
        dist_sq = dcx * dcx + drx * drx;
        rad_sq  = rx * rx;
        in_disk = (dist_sq <= rad_sq);

        ix = CW'(r_px) + CW'(dc);
        iy = CW'(r_py) + CW'(dr);
        wx = signed'(CW'(i_width));
        hx = signed'(CW'(i_height));
        on_canvas = !ix[CW-1] && (ix < wx) && !iy[CW-1] && (iy < hx);

        two_r  = {i_radius, 1'b0};
        e2     = (EW + 1)'(r_err) <<< 1;
        step_x = e2 > -(EW + 1)'(signed'({1'b0, r_dy}));
        step_y = e2 < (EW + 1)'(signed'({1'b0, r_dx}));

        if (i_op == OP_START) begin
            n_px    = signed'(i_start_x);
            n_py    = signed'(i_start_y);
            n_tx    = signed'(i_end_x);
            n_ty    = signed'(i_end_y);
            n_dx    = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
            n_dy    = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
            n_neg_x = !(signed'(i_start_x) < signed'(i_end_x));
            n_neg_y = !(signed'(i_start_y) < signed'(i_end_y));
            n_err   = EW'(signed'({1'b0, n_dx})) - EW'(signed'({1'b0, n_dy}));
            n_col   = '0;
            n_row   = '0;
            n_active = 1'b1;
        end else if (!r_active) begin
            o_result.done = 1'b1;
        end else begin
            if (in_disk && on_canvas) begin
                o_result.erase = 1'b1;
                o_result.px    = PIX_BITS'(ix);
                o_result.py    = PIX_BITS'(iy);
            end
            if (r_row < two_r) begin
                n_row = r_row + 1'b1;
            end else begin
                n_row = '0;
                if (r_col < two_r) begin
                    n_col = r_col + 1'b1;
                end else begin
                    n_col = '0;
                    if (r_px == r_tx && r_py == r_ty) begin
                        n_active      = 1'b0;
                        o_result.done = 1'b1;
                    end else begin
                        if (step_x) begin
                            n_px = r_neg_x ? r_px - 1'b1 : r_px + 1'b1;
                        end
                        if (step_y) begin
                            n_py = r_neg_y ? r_py - 1'b1 : r_py + 1'b1;
                        end
                        n_err = r_err
                              - (step_x ? EW'(signed'({1'b0, r_dy})) : EW'(0))
                              + (step_y ? EW'(signed'({1'b0, r_dx})) : EW'(0));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_px <= '0;  r_py <= '0;  r_tx <= '0;  r_ty <= '0;
            r_dx <= '0;  r_dy <= '0;
            r_neg_x <= 1'b0;  r_neg_y <= 1'b0;
            r_err <= '0;
            r_col <= '0;  r_row <= '0;
        end else if (i_step) begin
            r_active <= n_active;
            r_px <= n_px;  r_py <= n_py;  r_tx <= n_tx;  r_ty <= n_ty;
            r_dx <= n_dx;  r_dy <= n_dy;
            r_neg_x <= n_neg_x;  r_neg_y <= n_neg_y;
            r_err <= n_err;
            r_col <= n_col;  r_row <= n_row;
        end
    end

    assign o_active = r_active;

endmodule

// ===== src/thick_line_disk_brush_raster.sv =====
// Top level of the thick line disk brush raster: handshakes and result register.
//
// Each input beat yields exactly one output beat. A start beat (tuser 0) loads
// a segment and answers with an all-zero result; each advance beat (tuser 1)
// tests one candidate pixel of the (2r+1)-square brush scan around the current
// line point and answers erase/position, with tlast on the final candidate or
// when no segment is loaded. One beat per clock: the line step, the disk test
// and the canvas clip all resolve between the walk state and the output
// register, so the block accepts a new beat every cycle the output register is
// free or being drained. Configuration writes are always taken.
module thick_line_disk_brush_raster
    import thldb_pkg::*;
#(
    parameter int MAX_CANVAS    = DEF_MAX_CANVAS,
    parameter int MAX_THICKNESS = DEF_MAX_THICKNESS,
    parameter int COORD_BITS    = DEF_COORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]         i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // start_x, start_y, end_x, end_y, then zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel_x, pixel_y
    output logic [2*PIX_BITS-1:0]           m_axis_tdata,
    // erase_pixel
    output logic                            m_axis_tuser,
    // segment_done
    output logic                            m_axis_tlast
);

    localparam int CANVW = $clog2(MAX_CANVAS + 1);
    localparam int RW    = $clog2(MAX_THICKNESS / 2 + 2);

    logic [CANVW-1:0] width, height;
    logic [RW-1:0]    radius;
    logic             accept, walk_active;
    t_result          result;
    t_result          r_result;
    logic             r_valid;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    thldb_cfg #(
        .MAX_CANVAS    (MAX_CANVAS),
        .MAX_THICKNESS (MAX_THICKNESS),
        .CANVW         (CANVW),
        .RW            (RW)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (i_cfg_valid && o_cfg_ready),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_width  (width),
        .o_height (height),
        .o_radius (radius)
    );

    thldb_walk #(
        .COORD_BITS    (COORD_BITS),
        .MAX_CANVAS    (MAX_CANVAS),
        .MAX_THICKNESS (MAX_THICKNESS),
        .CANVW         (CANVW),
        .RW            (RW)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (accept),
        .i_op      (s_axis_tuser),
        .i_start_x (s_axis_tdata[0*COORD_BITS +: COORD_BITS]),
        .i_start_y (s_axis_tdata[1*COORD_BITS +: COORD_BITS]),
        .i_end_x   (s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
        .i_end_y   (s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
        .i_width   (width),
        .i_height  (height),
        .i_radius  (radius),
        .o_result  (result),
        .o_active  (walk_active)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_result.py, r_result.px};
    assign m_axis_tuser  = r_result.erase;
    assign m_axis_tlast  = r_result.done;

    // a start beat arms the walk and answers with an empty result
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tuser == OP_START |=>
            walk_active && m_axis_tvalid && !m_axis_tuser && !m_axis_tlast
            && m_axis_tdata == '0)
        else $error("start beat result not empty or walk not armed");

    // advancing with no segment loaded reports done and nothing erased
    a_idle_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tuser == OP_ADVANCE && !walk_active |=>
            m_axis_tlast && !m_axis_tuser && !walk_active)
        else $error("idle advance misreported");

    // no erase means zero coordinates
    a_zero_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("coordinates set without erase");

    // a done advance always leaves the walk idle
    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tuser == OP_ADVANCE && result.done |=> !walk_active)
        else $error("walk still active after segment end");

endmodule
